// ===== sv/ufsf_pkg.sv =====
// shared types and constants for the utf-8 structural filter
package ufsf_pkg;

    localparam int unsigned QUEUE_DEPTH_DEF = 2;
    localparam int unsigned MAX_RUN         = 4;
    localparam int unsigned HELD_DEPTH      = 3;

    localparam logic [7:0] ASCII_MAX  = 8'h7F;
    localparam logic [7:0] CONT_MASK  = 8'hC0;
    localparam logic [7:0] CONT_CODE  = 8'h80;
    localparam logic [7:0] LEAD2_MASK = 8'hE0;
    localparam logic [7:0] LEAD2_CODE = 8'hC0;
    localparam logic [7:0] LEAD3_MASK = 8'hF0;
    localparam logic [7:0] LEAD3_CODE = 8'hE0;
    localparam logic [7:0] LEAD4_MASK = 8'hF8;
    localparam logic [7:0] LEAD4_CODE = 8'hF0;

    localparam logic [2:0] SEQ_NONE = 3'd0;
    localparam logic [2:0] SEQ_LEN2 = 3'd2;
    localparam logic [2:0] SEQ_LEN3 = 3'd3;
    localparam logic [2:0] SEQ_LEN4 = 3'd4;

    // one request's worth of results, queued from front to back
    typedef struct packed {
        logic [MAX_RUN-1:0][7:0] bytes;
        logic [1:0]              last_idx;
        logic                    has_byte;
        logic                    msg_last;
    } ufsf_job_t;

    typedef struct packed {
        logic seq_open;
    } ufsf_front_status_t;

endpackage

// ===== sv/utf8_structural_filter.sv =====
// top level of the utf-8 structural filter: front, job queue and back
//
// input channel: one raw byte per request (in_byte) with message_last on the
//   final byte of a message; in_valid/in_ready handshake
// output channel: one result per request (out_byte, has_byte, run_last,
//   message_end); out_valid/out_ready handshake
// an ascii byte gives one result, a completed 2..4 byte sequence gives all
//   its bytes in order, a final byte that emits nothing gives a bare end
//   marker (has_byte low), other bytes give no result
// path: a result passes from the front into the job queue, then from the queue
//   into the output register
// throughput: one byte per cycle while runs are single results and out_ready is high;
//   the back drains one result per cycle while out_ready is high, so a run of n results
//   holds the back until all n drain and the queue (QUEUE_DEPTH jobs) absorbs the difference
// in_ready is low only when the job queue is full
// receiver stall: the output register holds, the queue fills, then input
//   stalls; nothing is lost or repeated
// reset: asynchronous, clears open sequence, queue and output valid
module utf8_structural_filter #(
    parameter int unsigned QUEUE_DEPTH = ufsf_pkg::QUEUE_DEPTH_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] in_byte,
    input  logic       message_last,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] out_byte,
    output logic       has_byte,
    output logic       run_last,
    output logic       message_end
);
    import ufsf_pkg::*;

    localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);

    logic               accept;
    logic               push;
    logic               pop;
    ufsf_job_t          front_job;
    ufsf_job_t          head_job;
    ufsf_front_status_t front_status;
    logic               q_not_empty;
    logic               q_full;
    logic [CW-1:0]      q_count;

    // a request is taken whenever the queue has room
    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;

    // classification and sequence holding
    ufsf_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (accept),
        .in_byte      (in_byte),
        .message_last (message_last),
        .push         (push),
        .job          (front_job),
        .status       (front_status)
    );

    // decouples the front, one byte per cycle while the queue has room, from multi-result runs
    ufsf_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .wr_job    (front_job),
        .pop       (pop),
        .rd_job    (head_job),
        .not_empty (q_not_empty),
        .full      (q_full),
        .count     (q_count)
    );

    // result sequencing into the output register
    ufsf_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head_job    (head_job),
        .head_valid  (q_not_empty),
        .pop         (pop),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_byte    (out_byte),
        .has_byte    (has_byte),
        .run_last    (run_last),
        .message_end (message_end)
    );

    // message end always closes any open sequence
    a_last_closes_seq : assert property (@(posedge clk) disable iff (!rst_n)
        accept && message_last |=> !front_status.seq_open)
        else $error("sequence still open after message end");

    // queue occupancy bounded by its depth
    a_queue_bound : assert property (@(posedge clk) disable iff (!rst_n)
        q_count <= CW'(QUEUE_DEPTH))
        else $error("job queue overflow");

    // a bare end marker carries zero and closes both run and message
    a_bare_marker : assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !has_byte |-> out_byte == 8'h00 && run_last && message_end)
        else $error("malformed end marker");

    // message end only on the last result of a run
    a_end_on_run_last : assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && message_end |-> run_last)
        else $error("message end inside a run");

endmodule

// ===== sv/ufsf_front.sv =====
// front end: classifies each byte, holds open sequences, builds result jobs
module ufsf_front (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        accept,
    input  logic [7:0]                  in_byte,
    input  logic                        message_last,
    output logic                        push,
    output ufsf_pkg::ufsf_job_t         job,
    output ufsf_pkg::ufsf_front_status_t status
);
    import ufsf_pkg::*;

    logic [2:0] seq_len_reg, seq_len_next;
    logic [1:0] hc_reg, hc_next;
    logic [7:0] held_reg  [HELD_DEPTH];
    logic [7:0] held_next [HELD_DEPTH];
    logic       emit;
    logic       fresh;
    logic       is_cont;

    always_comb
    begin
        seq_len_next = seq_len_reg;
        hc_next      = hc_reg;
        held_next    = held_reg;
        job          = '0;
        job.has_byte = 1'b1;
        emit         = 1'b0;
        fresh        = 1'b1;
        is_cont      = (in_byte & CONT_MASK) == CONT_CODE;

        if (seq_len_reg != SEQ_NONE && is_cont)
        begin
            fresh = 1'b0;
            if ({1'b0, hc_reg} + 3'd1 >= seq_len_reg)
            begin
                // sequence complete: held bytes then this one
                job.bytes[0] = (hc_reg == 2'd0) ? in_byte : held_reg[0];
                job.bytes[1] = (hc_reg <= 2'd1) ? in_byte : held_reg[1];
                job.bytes[2] = (hc_reg <= 2'd2) ? in_byte : held_reg[2];
                job.bytes[3] = in_byte;
                job.last_idx = hc_reg;
                emit         = 1'b1;
                seq_len_next = SEQ_NONE;
                hc_next      = 2'd0;
            end
            else
            begin
                if (hc_reg != 2'd3)
                begin
                    held_next[hc_reg] = in_byte;
                end
                hc_next = hc_reg + 2'd1;
            end
        end

        if (fresh)
        begin
            seq_len_next = SEQ_NONE;
            hc_next      = 2'd0;
            priority if (in_byte <= ASCII_MAX)
            begin
                job.bytes[0] = in_byte;
                job.last_idx = 2'd0;
                emit         = 1'b1;
            end
            else if ((in_byte & LEAD2_MASK) == LEAD2_CODE)
            begin
                held_next[0] = in_byte;
                hc_next      = 2'd1;
                seq_len_next = SEQ_LEN2;
            end
            else if ((in_byte & LEAD3_MASK) == LEAD3_CODE)
            begin
                held_next[0] = in_byte;
                hc_next      = 2'd1;
                seq_len_next = SEQ_LEN3;
            end
            else if ((in_byte & LEAD4_MASK) == LEAD4_CODE)
            begin
                held_next[0] = in_byte;
                hc_next      = 2'd1;
                seq_len_next = SEQ_LEN4;
            end
            else
            begin
                // stray continuation or 0xf8 upwards: dropped
                emit = 1'b0;
            end
        end

        if (message_last)
        begin
            seq_len_next = SEQ_NONE;
            hc_next      = 2'd0;
            job.msg_last = 1'b1;
            if (!emit)
            begin
                // bare end marker
                job.bytes    = '0;
                job.has_byte = 1'b0;
                job.last_idx = 2'd0;
                emit         = 1'b1;
            end
        end
    end

    assign push            = accept && emit;
    assign status.seq_open = seq_len_reg != SEQ_NONE;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seq_len_reg <= SEQ_NONE;
            hc_reg      <= 2'd0;
        end
        else if (accept)
        begin
            seq_len_reg <= seq_len_next;
            hc_reg      <= hc_next;
        end
    end

    // held bytes are only read after being written in the same sequence
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            held_reg <= held_next;
        end
    end

endmodule

// ===== sv/ufsf_queue.sv =====
// short job queue between front and back
module ufsf_queue #(
    parameter int unsigned DEPTH = ufsf_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  ufsf_pkg::ufsf_job_t wr_job,
    input  logic                pop,
    output ufsf_pkg::ufsf_job_t rd_job,
    output logic                not_empty,
    output logic                full,
    output logic [$clog2(DEPTH+1)-1:0] count
);
    import ufsf_pkg::*;

    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);

    ufsf_job_t         slot_reg [DEPTH];
    logic [AW-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]     count_reg, count_next;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + AW'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + AW'(1);
        end
        unique case ({push, pop})
            2'b10:   count_next = count_reg + CW'(1);
            2'b01:   count_next = count_reg - CW'(1);
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= wr_job;
        end
    end

    assign rd_job    = slot_reg[rd_ptr_reg];
    assign not_empty = count_reg != '0;
    assign full      = count_reg == CW'(DEPTH);
    assign count     = count_reg;

endmodule

// ===== sv/ufsf_back.sv =====
// back end: walks the head job one result per cycle, while the receiver is ready, into the output register
module ufsf_back (
    input  logic                clk,
    input  logic                rst_n,
    input  ufsf_pkg::ufsf_job_t head_job,
    input  logic                head_valid,
    output logic                pop,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [7:0]          out_byte,
    output logic                has_byte,
    output logic                run_last,
    output logic                message_end
);
    import ufsf_pkg::*;

    logic [1:0] idx_reg, idx_next;
    logic       valid_reg;
    logic [7:0] byte_reg;
    logic       has_reg;
    logic       run_last_reg;
    logic       end_reg;
    logic       load;
    logic       at_last;

    assign load     = head_valid && (!valid_reg || out_ready);
    assign at_last  = idx_reg == head_job.last_idx;
    assign pop      = load && at_last;
    assign idx_next = at_last ? 2'd0 : idx_reg + 2'd1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            idx_reg   <= 2'd0;
        end
        else
        begin
            if (load)
            begin
                valid_reg <= 1'b1;
                idx_reg   <= idx_next;
            end
            else if (out_ready)
            begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            byte_reg     <= head_job.bytes[idx_reg];
            has_reg      <= head_job.has_byte;
            run_last_reg <= at_last;
            end_reg      <= at_last && head_job.msg_last;
        end
    end

    assign out_valid   = valid_reg;
    assign out_byte    = byte_reg;
    assign has_byte    = has_reg;
    assign run_last    = run_last_reg;
    assign message_end = end_reg;

endmodule

// ===== tb/utf8_structural_filter_tb.sv =====
// self-checking testbench for the utf-8 structural filter: directed and random requests
`timescale 1ns / 1ps

module utf8_structural_filter_tb;

    import ufsf_pkg::*;

    // no request accepted on either side for this long means the block has hung
    localparam int unsigned HANG_LIMIT    = 2000;
    // results trail their request through the queue and output register, so a short settle is plenty
    localparam int unsigned SETTLE_CYCLES = 8;
    localparam int unsigned REPORT_MAX    = 10;
    localparam int unsigned RANDOM_ITEMS  = 75;

    // one filtered result, fields in port order
    typedef struct packed {
        logic [7:0] out_byte;
        logic       has_byte;
        logic       run_last;
        logic       message_end;
    } filtered_result_t;

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_ready;
    logic [7:0] in_byte;
    logic       message_last;
    logic       out_valid;
    logic       out_ready;
    logic [7:0] out_byte;
    logic       has_byte;
    logic       run_last;
    logic       message_end;

    // predicted results still waiting for the block to produce them
    filtered_result_t awaited_results[$];

    // predictor copy of the sequence tracking
    logic [7:0] held_bytes[HELD_DEPTH];
    logic [1:0] held_count;
    logic [2:0] sequence_length;

    // bytes of the message being built by the random generator
    logic [7:0] message_bytes[$];

    int unsigned send_idle_pct;
    int unsigned recv_stall_pct;
    int unsigned mismatch_count;
    int unsigned requests_sent;

    utf8_structural_filter u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .in_byte      (in_byte),
        .message_last (message_last),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .out_byte     (out_byte),
        .has_byte     (has_byte),
        .run_last     (run_last),
        .message_end  (message_end)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // works out the results of one accepted request and queues them in order
    function automatic void predict_filtered(input logic [7:0] b, input logic last);
        filtered_result_t run[MAX_RUN];
        int               n;
        bit               judge_fresh;
        n           = 0;
        judge_fresh = 1'b1;
        if (sequence_length != SEQ_NONE)
        begin
            if ((b & CONT_MASK) == CONT_CODE)
            begin
                judge_fresh = 1'b0;
                if ({1'b0, held_count} + 3'd1 >= sequence_length)
                begin
                    // sequence complete: lead and continuations go out together
                    for (int i = 0; i < held_count; i++)
                    begin
                        run[n] = {held_bytes[i], 1'b1, 1'b0, 1'b0};
                        n++;
                    end
                    run[n] = {b, 1'b1, 1'b0, 1'b0};
                    n++;
                    held_count      = 2'd0;
                    sequence_length = SEQ_NONE;
                end
                else
                begin
                    held_bytes[held_count] = b;
                    held_count             = held_count + 2'd1;
                end
            end
            else
            begin
                // broken sequence: drop what is held and judge this byte afresh
                held_count      = 2'd0;
                sequence_length = SEQ_NONE;
            end
        end
        if (judge_fresh)
        begin
            if (b <= ASCII_MAX)
            begin
                run[n] = {b, 1'b1, 1'b0, 1'b0};
                n++;
            end
            else if ((b & LEAD2_MASK) == LEAD2_CODE)
            begin
                held_bytes[0]   = b;
                held_count      = 2'd1;
                sequence_length = SEQ_LEN2;
            end
            else if ((b & LEAD3_MASK) == LEAD3_CODE)
            begin
                held_bytes[0]   = b;
                held_count      = 2'd1;
                sequence_length = SEQ_LEN3;
            end
            else if ((b & LEAD4_MASK) == LEAD4_CODE)
            begin
                held_bytes[0]   = b;
                held_count      = 2'd1;
                sequence_length = SEQ_LEN4;
            end
            // stray continuations and 0xf8 upwards fall through and vanish
        end
        if (last)
        begin
            // message end discards any unfinished sequence
            held_count      = 2'd0;
            sequence_length = SEQ_NONE;
            if (n == 0)
            begin
                run[n] = {8'h00, 1'b0, 1'b0, 1'b0};
                n++;
            end
            run[n-1].message_end = 1'b1;
        end
        if (n > 0)
            run[n-1].run_last = 1'b1;
        for (int i = 0; i < n; i++)
            awaited_results.insert(awaited_results.size(), run[i]);
    endfunction

    // presents one request from a falling edge, with random idle cycles first;
    // valid is only lowered while idling, so back-to-back requests keep it high
    task automatic send_byte(input logic [7:0] b, input logic last);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_valid     = 1'b1;
        in_byte      = b;
        message_last = last;
        do
            @(posedge clk);
        while (!in_ready);
        predict_filtered(b, last);
        requests_sent++;
        @(negedge clk);
    endtask

    // receiver side: ready changes on the falling edge only
    initial
    begin
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            out_ready = ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // result checker: every accepted result is matched against the oldest prediction
    always @(posedge clk)
    begin
        filtered_result_t seen;
        filtered_result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            seen = {out_byte, has_byte, run_last, message_end};
            if (awaited_results.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= REPORT_MAX)
                    $display("unexpected result: byte %02h has %0b run_last %0b end %0b",
                             out_byte, has_byte, run_last, message_end);
            end
            else
            begin
                want = awaited_results.pop_front();
                if (seen !== want)
                begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_MAX)
                        $display("mismatch: expected %02h/%0b/%0b/%0b got %02h/%0b/%0b/%0b",
                                 want.out_byte, want.has_byte, want.run_last,
                                 want.message_end, out_byte, has_byte, run_last,
                                 message_end);
                end
            end
        end
    end

    // hang detector: counts cycles in which neither side moves a request
    initial
    begin
        int unsigned quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < HANG_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("[utf8_structural_filter] ERROR");
        $finish;
    end

    // adds one byte to the end of the message being built
    function automatic void add_byte(input logic [7:0] b);
        message_bytes.insert(message_bytes.size(), b);
    endfunction

    // appends one random character, mostly well formed, to the message being built
    function automatic void append_char();
        int unsigned kind;
        int unsigned seq_len;
        int unsigned partial;
        kind = $urandom_range(99);
        if (kind < 35)
            add_byte(8'($urandom_range(127)));
        else if (kind < 50)
        begin
            add_byte(LEAD2_CODE | 8'($urandom_range(31)));
            add_byte(CONT_CODE | 8'($urandom_range(63)));
        end
        else if (kind < 63)
        begin
            add_byte(LEAD3_CODE | 8'($urandom_range(15)));
            repeat (2) add_byte(CONT_CODE | 8'($urandom_range(63)));
        end
        else if (kind < 76)
        begin
            add_byte(LEAD4_CODE | 8'($urandom_range(7)));
            repeat (3) add_byte(CONT_CODE | 8'($urandom_range(63)));
        end
        else if (kind < 84)
            add_byte(CONT_CODE | 8'($urandom_range(63)));
        else if (kind < 90)
            add_byte(8'hF8 | 8'($urandom_range(7)));
        else
        begin
            // lead with too few continuations, so the next non-continuation byte breaks it
            seq_len = $urandom_range(4, 2);
            partial = $urandom_range(seq_len - 2);
            case (seq_len)
                2:       add_byte(LEAD2_CODE | 8'($urandom_range(31)));
                3:       add_byte(LEAD3_CODE | 8'($urandom_range(15)));
                default: add_byte(LEAD4_CODE | 8'($urandom_range(7)));
            endcase
            repeat (partial) add_byte(CONT_CODE | 8'($urandom_range(63)));
        end
    endfunction

    // ascii extremes and one sequence of every length, four-byte one closing the message
    task automatic test_ascii_and_sequences();
        send_byte(8'h00, 1'b0);
        send_byte(8'h7F, 1'b0);
        send_byte(8'h41, 1'b1);
        send_byte(8'hC2, 1'b0);
        send_byte(8'hA9, 1'b0);
        send_byte(8'hE2, 1'b0);
        send_byte(8'h82, 1'b0);
        send_byte(8'hAC, 1'b0);
        send_byte(8'hF0, 1'b0);
        send_byte(8'h9F, 1'b0);
        send_byte(8'h98, 1'b0);
        send_byte(8'h80, 1'b1);
    endtask

    // stray continuations and bytes that can never start a character; the last one
    // ends a message with nothing emitted and so gives a bare end marker
    task automatic test_invalid_bytes();
        send_byte(8'h80, 1'b0);
        send_byte(8'hBF, 1'b0);
        send_byte(8'hF8, 1'b0);
        send_byte(8'hFF, 1'b1);
    endtask

    // sequences broken by ascii and by a new lead, then ones cut off by message end
    task automatic test_broken_and_truncated();
        send_byte(8'hC3, 1'b0);
        send_byte(8'h41, 1'b0);
        send_byte(8'hEF, 1'b0);
        send_byte(8'hBF, 1'b0);
        send_byte(8'hC0, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(8'hF7, 1'b0);
        send_byte(8'hBF, 1'b0);
        send_byte(8'hBF, 1'b1);
        send_byte(8'hDF, 1'b1);
    endtask

    // random messages under one idling mix; some lose their final byte so that
    // the message may end in the middle of a sequence
    task automatic test_random_messages(input int unsigned idle_pct,
                                        input int unsigned stall_pct);
        int unsigned target;
        int unsigned chars;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        target         = requests_sent + RANDOM_ITEMS;
        while (requests_sent < target)
        begin
            message_bytes.delete();
            chars = $urandom_range(10, 1);
            repeat (chars) append_char();
            if (message_bytes.size() > 1 && $urandom_range(9) == 0)
                void'(message_bytes.pop_back());
            foreach (message_bytes[i])
                send_byte(message_bytes[i], (i == message_bytes.size() - 1));
        end
    endtask

    initial
    begin
        rst_n           = 1'b0;
        in_valid        = 1'b0;
        in_byte         = 8'h00;
        message_last    = 1'b0;
        send_idle_pct   = 0;
        recv_stall_pct  = 0;
        mismatch_count  = 0;
        requests_sent   = 0;
        held_count      = 2'd0;
        sequence_length = SEQ_NONE;
        foreach (held_bytes[i])
            held_bytes[i] = 8'h00;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_ascii_and_sequences();
        test_invalid_bytes();
        test_broken_and_truncated();
        test_random_messages(0, 0);
        test_random_messages(45, 0);
        test_random_messages(0, 45);
        test_random_messages(32, 32);

        in_valid = 1'b0;
        // drain whatever is still in flight, then watch for strays
        while (awaited_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && awaited_results.size() == 0)
            $display("[utf8_structural_filter] OK");
        else
            $display("[utf8_structural_filter] ERROR");
        $finish;
    end

endmodule

// ===== filelist.f =====
sv/ufsf_pkg.sv
sv/ufsf_front.sv
sv/ufsf_queue.sv
sv/ufsf_back.sv
sv/utf8_structural_filter.sv
tb/utf8_structural_filter_tb.sv
